// ===== sv/aes_cbc_block_cipher_macros.svh =====
// Assertion macros for the AES CBC block cipher RTL.
// Included by modules that carry concurrent assertions; needs clock and reset.
`ifndef AES_CBC_BLOCK_CIPHER_MACROS_SVH
`define AES_CBC_BLOCK_CIPHER_MACROS_SVH

// same-cycle implication
`define ACB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle rule");

// next-cycle implication
`define ACB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle rule");

`endif

// ===== sv/aes_cbc_pkg.sv =====
// Shared constants, types and GF(2^8) functions for the AES CBC cipher.
// No dependencies; imported by every module of the block.
package aes_cbc_pkg;

   localparam int KEY_WORDS   = 60;
   localparam int BLOCK_BYTES = 16;
   localparam int KEY_ADDR_W  = $clog2(2 * KEY_WORDS);
   localparam int MIN_ROUNDS  = 10;
   localparam int MAX_ROUNDS  = 14;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_ENCRYPT = 2'd1;
   localparam logic [1:0] OP_DECRYPT = 2'd2;

   typedef struct packed {
      logic                  en;
      logic [KEY_ADDR_W-1:0] addr;
   } key_wr_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         x = xtime(x);
      end
      return acc;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int s);
      return 8'((v << s) | (v >> (8 - s)));
   endfunction

   // evaluated at elaboration only
   function automatic logic [2047:0] build_box(input logic inverse);
      logic [2047:0] fwd;
      logic [2047:0] inv_tab;
      logic [7:0]    inv;
      logic [7:0]    base;
      logic [7:0]    s;
      logic [7:0]    e;
      fwd     = '0;
      inv_tab = '0;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         if (x != 0) begin
            base = 8'(x);
            e    = 8'd254;
            inv  = 8'h01;
            for (int k = 0; k < 8; k++) begin
               if (e[0]) inv = gf_mul(inv, base);
               base = gf_mul(base, base);
               e    = e >> 1;
            end
         end
         s = 8'h63 ^ inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4);
         fwd[8*x +: 8]     = s;
         inv_tab[8*s +: 8] = 8'(x);
      end
      return inverse ? inv_tab : fwd;
   endfunction

   localparam logic [2047:0] FWD_BOX = build_box(1'b0);
   localparam logic [2047:0] INV_BOX = build_box(1'b1);

   function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inverse);
      logic [7:0]  a [4];
      logic [7:0]  k [4];
      logic [7:0]  v;
      logic [31:0] r;
      for (int j = 0; j < 4; j++) a[j] = col[31-8*j -: 8];
      if (inverse) begin
         k[0] = 8'h0E; k[1] = 8'h0B; k[2] = 8'h0D; k[3] = 8'h09;
      end else begin
         k[0] = 8'h02; k[1] = 8'h03; k[2] = 8'h01; k[3] = 8'h01;
      end
      r = '0;
      for (int i = 0; i < 4; i++) begin
         v = 8'h00;
         for (int j = 0; j < 4; j++) v = v ^ gf_mul(a[j], k[(j + 4 - i) & 3]);
         r[31-8*i -: 8] = v;
      end
      return r;
   endfunction

endpackage

// ===== sv/aes_cbc_key_mem.sv =====
// Round-key store: encryption and decryption schedules in one memory.
// Depends on aes_cbc_pkg; one write port, one registered read port.
module aes_cbc_key_mem (
   input  logic                                clock,
   input  aes_cbc_pkg::key_wr_type             wr,
   input  logic [31:0]                         wr_data,
   input  logic [aes_cbc_pkg::KEY_ADDR_W-1:0]  rd_addr,
   output logic [31:0]                         rd_data
);
   import aes_cbc_pkg::*;

   logic [31:0] mem_ff [2*KEY_WORDS];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) mem_ff[wr.addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/aes_cbc_core.sv =====
// Byte-serial AES round engine: S-box one byte a cycle, mix and key add one column a cycle.
// Depends on aes_cbc_pkg and the macro header; reads round keys from aes_cbc_key_mem.
`include "aes_cbc_block_cipher_macros.svh"

module aes_cbc_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [127:0]                        start_block,
   input  logic                                start_inverse,
   input  logic [3:0]                          start_rounds,
   input  logic                                done_ack,
   output aes_cbc_pkg::core_status_type        status,
   output logic [127:0]                        result,
   output logic [aes_cbc_pkg::KEY_ADDR_W-1:0]  key_rd_addr,
   input  logic [31:0]                         key_rd_data
);
   import aes_cbc_pkg::*;

   typedef enum logic [2:0] {IDLE, ADD, SUB, SHIFT, MIX, DONE} state_type;

   state_type    state_ff, state_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [3:0]   rd_ff, rd_in;
   logic [3:0]   rounds_ff, rounds_in;
   logic         inv_ff, inv_in;
   logic [127:0] blk_ff, blk_in;
   logic [5:0]   word_idx;

   function automatic logic [127:0] shift_rows(input logic [127:0] b, input logic inverse);
      logic [127:0] t;
      int           src;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = inverse ? ((c + 4 - r) & 3) : ((c + r) & 3);
            t[127-8*(4*c+r) -: 8] = b[127-8*(4*src+r) -: 8];
         end
      end
      return t;
   endfunction

   function automatic logic [7:0] sub_byte(input logic [7:0] v, input logic inverse);
      return inverse ? INV_BOX[{v, 3'b000} +: 8] : FWD_BOX[{v, 3'b000} +: 8];
   endfunction

   assign word_idx    = {rd_ff, 2'b00} + {4'b0000, cnt_ff[1:0]};
   assign key_rd_addr = KEY_ADDR_W'(word_idx) + (inv_ff ? KEY_ADDR_W'(KEY_WORDS) : '0);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      rd_in     = rd_ff;
      rounds_in = rounds_ff;
      inv_in    = inv_ff;
      blk_in    = blk_ff;
      case (state_ff)
         IDLE: begin
            if (start) begin
               blk_in    = start_block;
               inv_in    = start_inverse;
               rounds_in = start_rounds;
               rd_in     = '0;
               cnt_in    = '0;
               state_in  = ADD;
            end
         end
         ADD: begin
            if (cnt_ff != 4'd0) blk_in = {blk_ff[95:0], blk_ff[127:96] ^ key_rd_data};
            if (cnt_ff == 4'd4) begin
               cnt_in = '0;
               if (rd_ff == rounds_ff) begin
                  state_in = DONE;
               end else begin
                  rd_in    = rd_ff + 4'd1;
                  state_in = SUB;
               end
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         SUB: begin
            blk_in = {blk_ff[119:0], sub_byte(blk_ff[127:120], inv_ff)};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) state_in = SHIFT;
         end
         SHIFT: begin
            blk_in   = shift_rows(blk_ff, inv_ff);
            state_in = (rd_ff == rounds_ff) ? ADD : MIX;
         end
         MIX: begin
            blk_in = {blk_ff[95:0], mix_col(blk_ff[127:96], inv_ff)};
            if (cnt_ff == 4'd3) begin
               cnt_in   = '0;
               state_in = ADD;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         DONE: begin
            if (done_ack) state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         cnt_ff    <= '0;
         rd_ff     <= '0;
         rounds_ff <= 4'(MIN_ROUNDS);
         inv_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         rd_ff     <= rd_in;
         rounds_ff <= rounds_in;
         inv_ff    <= inv_in;
      end
      blk_ff <= blk_in;
   end

   assign status.idle = (state_ff == IDLE);
   assign status.done = (state_ff == DONE);
   assign result      = blk_ff;

   `ACB_ASSERT_NOW(a_start_idle, start, state_ff == IDLE)
   `ACB_ASSERT_NOW(a_mix_not_last, state_ff == MIX, rd_ff != rounds_ff)
   `ACB_ASSERT_NOW(a_done_all_rounds, state_ff == DONE, rd_ff == rounds_ff)
   `ACB_ASSERT_NEXT(a_shift_next, state_ff == SHIFT, state_ff == MIX || state_ff == ADD)

endmodule

// ===== sv/aes_cbc_block_cipher.sv =====
// Top level of the AES CBC cipher: handshake, chain value, result register.
// Depends on aes_cbc_pkg, aes_cbc_key_mem and aes_cbc_core.
//
//   channel | ports              | direction
//   req     | req_valid/ready    | in: key load, encrypt, decrypt
//   rsp     | rsp_valid/ready    | out: one result per encrypt or decrypt
//   csr     | csr_wr_en/wr_data  | in: round count
//
// In the core, an initial key add is followed by rounds of 16 byte-serial S-box steps,
// one shift step, four mix-column steps (not in the last round) and five key-add steps
// on the key port. A key load is written when it is accepted. req_ready is high while
// the core is idle. A finished result waits in the core while rsp holds an untaken one.
// Reset clears the chain value to zero and sets the round count to 10.
module aes_cbc_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic        req_schedule_select,
   input  logic [5:0]  req_key_word_index,
   input  logic [31:0] req_key_word,
   input  logic        req_chain_start,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   output logic [4:0]  rsp_valid_bytes,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   import aes_cbc_pkg::*;

   logic [3:0]      round_count_ff;
   logic [127:0]    chain_ff, chain_in;
   logic [127:0]    prev_ff;
   logic            dec_ff;
   logic [4:0]      count_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [127:0]    rsp_data_ff;
   logic [4:0]      rsp_bytes_ff;

   logic            accept;
   logic            start;
   logic [127:0]    blk;
   logic [127:0]    chain_use;
   logic [4:0]      count_norm;
   logic [3:0]      rounds_norm;
   logic [127:0]    start_block;
   logic            done_ack;
   logic [127:0]    core_result;
   logic [127:0]    dec_result;
   core_status_type status;
   key_wr_type      key_wr;
   logic [KEY_ADDR_W-1:0] key_rd_addr;
   logic [31:0]     key_rd_data;

   function automatic logic [127:0] byte_mask(input logic [4:0] count);
      logic [127:0] m;
      for (int i = 0; i < BLOCK_BYTES; i++) m[127-8*i -: 8] = (5'(i) < count) ? 8'hFF : 8'h00;
      return m;
   endfunction

   assign req_ready = status.idle;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_op == OP_ENCRYPT || req_op == OP_DECRYPT);
   assign blk       = {req_block_high, req_block_low};
   assign chain_use = req_chain_start ? '0 : chain_ff;
   assign count_norm = (req_byte_count == 5'd0 || req_byte_count > 5'(BLOCK_BYTES))
                       ? 5'(BLOCK_BYTES) : req_byte_count;
   assign rounds_norm = ({round_count_ff[3:1], 1'b0} < 4'(MIN_ROUNDS))
                        ? 4'(MIN_ROUNDS) : {round_count_ff[3:1], 1'b0};
   assign start_block = (req_op == OP_DECRYPT) ? blk : ((blk & byte_mask(count_norm)) ^ chain_use);

   assign key_wr.en   = accept && (req_op == OP_LOAD) && (req_key_word_index < 6'(KEY_WORDS));
   assign key_wr.addr = KEY_ADDR_W'(req_key_word_index)
                        + (req_schedule_select ? KEY_ADDR_W'(KEY_WORDS) : '0);

   assign done_ack   = status.done && (!rsp_valid_ff || rsp_ready);
   assign dec_result = (core_result ^ prev_ff) & byte_mask(count_ff);

   always_comb begin
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (done_ack) begin
         rsp_valid_in = 1'b1;
         if (!dec_ff) chain_in = core_result;
      end
      if (start && req_op == OP_DECRYPT) chain_in = blk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_count_ff <= 4'(MIN_ROUNDS);
         chain_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) round_count_ff <= csr_wr_data;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (start) begin
         prev_ff  <= chain_use;
         dec_ff   <= (req_op == OP_DECRYPT);
         count_ff <= count_norm;
      end
      if (done_ack) begin
         rsp_data_ff  <= dec_ff ? dec_result : core_result;
         rsp_bytes_ff <= dec_ff ? count_ff : 5'(BLOCK_BYTES);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_high = rsp_data_ff[127:64];
   assign rsp_result_low  = rsp_data_ff[63:0];
   assign rsp_valid_bytes = rsp_bytes_ff;

   aes_cbc_key_mem u_key_mem (
      .clock   (clock),
      .wr      (key_wr),
      .wr_data (req_key_word),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   aes_cbc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .start_block   (start_block),
      .start_inverse (req_op == OP_DECRYPT),
      .start_rounds  (rounds_norm),
      .done_ack      (done_ack),
      .status        (status),
      .result        (core_result),
      .key_rd_addr   (key_rd_addr),
      .key_rd_data   (key_rd_data)
   );

endmodule
